@@ rtl/core/vae_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vae_pkg
// Shared types, constants and tables of the voice allocator envelope core.
// ----------------------------------------------------------------------------
package vae_pkg;

	localparam int VOICE_COUNT = 4;
	localparam int RAMP_BITS   = 12;
	localparam int HIT_VOICES  = (VOICE_COUNT < 4) ? VOICE_COUNT : 4;

	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

	localparam logic [2:0] NO_VOICE = 3'd4;

	localparam logic [6:0] NOTE_LOW      = 7'd21;
	localparam logic [6:0] NOTE_HIGH     = 7'd119;
	localparam logic [6:0] LVL_PEAK_TRIG = 7'd120;
	localparam logic [6:0] LVL_MAX       = 7'd127;
	localparam logic [6:0] LVL_FLOOR     = 7'd10;

	typedef enum logic [2:0] {
		CFG_ATTACK_STEP  = 3'd0,
		CFG_DECAY_STEP   = 3'd1,
		CFG_RELEASE_STEP = 3'd2,
		CFG_SUSTAIN_IDX  = 3'd3,
		CFG_USE_ENVELOPE = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef struct packed {
		logic [31:0] attack_step;
		logic [31:0] decay_step;
		logic [31:0] release_step;
		logic [11:0] sustain_index;
		logic        use_envelope;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic start;
		logic stop;
	} voice_cmd_t;

	// linear 7-bit ramp over RAMP_BITS positions
	function automatic logic [6:0] ramp(input logic [RAMP_BITS-1:0] p);
		logic [RAMP_BITS+6:0] t;
		t = {p, 7'b0};
		return t[RAMP_BITS+6:RAMP_BITS];
	endfunction

	function automatic logic [6:0] level_of(input logic [31:0] idx);
		return ramp(idx[31 -: RAMP_BITS]);
	endfunction

	// phase step per note, 8 fraction bits
	function automatic logic [23:0] note_step(input logic [6:0] n);
		logic [23:0] s;
		case (n)
			7'd21:  s = 24'd46137;    7'd22:  s = 24'd48888;    7'd23:  s = 24'd51790;
			7'd24:  s = 24'd54861;    7'd25:  s = 24'd58132;    7'd26:  s = 24'd61588;
			7'd27:  s = 24'd65246;    7'd28:  s = 24'd69121;    7'd29:  s = 24'd73231;
			7'd30:  s = 24'd77593;    7'd31:  s = 24'd82207;    7'd32:  s = 24'd87089;
			7'd33:  s = 24'd92273;    7'd34:  s = 24'd97759;    7'd35:  s = 24'd103581;
			7'd36:  s = 24'd109738;   7'd37:  s = 24'd116264;   7'd38:  s = 24'd123176;
			7'd39:  s = 24'd130491;   7'd40:  s = 24'd138259;   7'd41:  s = 24'd146480;
			7'd42:  s = 24'd155187;   7'd43:  s = 24'd164414;   7'd44:  s = 24'd174195;
			7'd45:  s = 24'd184547;   7'd46:  s = 24'd195519;   7'd47:  s = 24'd207145;
			7'd48:  s = 24'd219459;   7'd49:  s = 24'd232512;   7'd50:  s = 24'd246336;
			7'd51:  s = 24'd260982;   7'd52:  s = 24'd276501;   7'd53:  s = 24'd292942;
			7'd54:  s = 24'd310374;   7'd55:  s = 24'd328828;   7'd56:  s = 24'd348374;
			7'd57:  s = 24'd369093;   7'd58:  s = 24'd391037;   7'd59:  s = 24'd414290;
			7'd60:  s = 24'd438936;   7'd61:  s = 24'd465024;   7'd62:  s = 24'd492672;
			7'd63:  s = 24'd521982;   7'd64:  s = 24'd553019;   7'd65:  s = 24'd585902;
			7'd66:  s = 24'd620731;   7'd67:  s = 24'd657657;   7'd68:  s = 24'd696747;
			7'd69:  s = 24'd738186;   7'd70:  s = 24'd782075;   7'd71:  s = 24'd828580;
			7'd72:  s = 24'd877854;   7'd73:  s = 24'd930064;   7'd74:  s = 24'd985361;
			7'd75:  s = 24'd1043946;  7'd76:  s = 24'd1106021;  7'd77:  s = 24'd1171804;
			7'd78:  s = 24'd1241478;  7'd79:  s = 24'd1315297;  7'd80:  s = 24'd1393511;
			7'd81:  s = 24'd1476372;  7'd82:  s = 24'd1564166;  7'd83:  s = 24'd1657178;
			7'd84:  s = 24'd1755709;  7'd85:  s = 24'd1860112;  7'd86:  s = 24'd1970722;
			7'd87:  s = 24'd2093029;  7'd88:  s = 24'd2212059;  7'd89:  s = 24'd2343590;
			7'd90:  s = 24'd2482957;  7'd91:  s = 24'd2630594;  7'd92:  s = 24'd2787022;
			7'd93:  s = 24'd2952745;  7'd94:  s = 24'd3128333;  7'd95:  s = 24'd3314339;
			7'd96:  s = 24'd3511418;  7'd97:  s = 24'd3720224;  7'd98:  s = 24'd3941445;
			7'd99:  s = 24'd4175819;  7'd100: s = 24'd4424118;  7'd101: s = 24'd4687197;
			7'd102: s = 24'd4965913;  7'd103: s = 24'd5261188;  7'd104: s = 24'd5574044;
			7'd105: s = 24'd5905490;  7'd106: s = 24'd6256648;  7'd107: s = 24'd6628694;
			7'd108: s = 24'd7017732;  7'd109: s = 24'd7440448;  7'd110: s = 24'd7882873;
			7'd111: s = 24'd8351621;  7'd112: s = 24'd8848236;  7'd113: s = 24'd9374378;
			7'd114: s = 24'd9931809;  7'd115: s = 24'd10522392; 7'd116: s = 24'd11142969;
			7'd117: s = 24'd11816100; 7'd118: s = 24'd12513297; 7'd119: s = 24'd13257372;
			default: s = 24'd0;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/voice_allocator_adsr_envelope_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_allocator_adsr_envelope_core
// Four-voice note allocator with a per-voice ADSR envelope.
// ----------------------------------------------------------------------------
// Takes one item (tick, note-on or note-off) per clock cycle while results are
// taken, and returns one result per item: the item is registered, all voices
// are updated in a single pass of combinational logic, and the result is held
// in an output register, so one new item is accepted while a result waits.
// The 32-bit envelope index add or subtract and the level lookup in each voice
// set the cycle. There is no clearing pass after reset.
module voice_allocator_adsr_envelope_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [6:0]  note,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  level_voice0,
	output logic [6:0]  level_voice1,
	output logic [6:0]  level_voice2,
	output logic [6:0]  level_voice3,
	output logic [2:0]  voice_hit,
	output logic [23:0] phase_step,
	output logic        note_rejected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NV = vae_pkg::VOICE_COUNT;

	vae_pkg::cfg_t cfg;

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [6:0] note_s1;
	logic       adv;

	logic        out_valid_q;
	logic [6:0]  level_q [4];
	logic [2:0]  hit_q;
	logic [23:0] step_q;
	logic        rej_q;

	vae_pkg::stage_t     stage [NV];
	logic [6:0]          vnote [NV];
	logic [6:0]          lvl_nxt [NV];
	vae_pkg::voice_cmd_t cmd [NV];

	logic        note_ok, is_tick, is_on, is_off;
	logic [NV-1:0] on_sel, off_sel;
	logic        found_on, found_off;
	logic [6:0]  sus_level;
	logic [2:0]  hit_d;
	logic [23:0] step_d;
	logic        rej_d;
	logic [6:0]  level_d [4];

	vae_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			note_s1 <= note;
		end
	end

	assign sus_level = vae_pkg::ramp(cfg.sustain_index[vae_pkg::RAMP_BITS-1:0]);
	assign note_ok   = (note_s1 >= vae_pkg::NOTE_LOW) && (note_s1 <= vae_pkg::NOTE_HIGH);
	assign is_tick   = (mode_s1 == vae_pkg::MODE_TICK);
	assign is_on     = (mode_s1 == vae_pkg::MODE_NOTE_ON);
	assign is_off    = (mode_s1 == vae_pkg::MODE_NOTE_OFF);

	// first idle voice for note-on, first voice holding the note in attack, decay or sustain for note-off
	always_comb begin
		found_on  = 1'b0;
		found_off = 1'b0;
		on_sel    = '0;
		off_sel   = '0;
		for (int v = 0; v < NV; v++) begin
			if (!found_on && stage[v] == vae_pkg::ST_IDLE) begin
				on_sel[v] = 1'b1;
				found_on  = 1'b1;
			end
			if (!found_off && vnote[v] == note_s1 &&
			    (stage[v] == vae_pkg::ST_ATTACK || stage[v] == vae_pkg::ST_DECAY ||
			     stage[v] == vae_pkg::ST_SUSTAIN)) begin
				off_sel[v] = 1'b1;
				found_off  = 1'b1;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NV; g++) begin : g_voice
			assign cmd[g].tick  = is_tick;
			assign cmd[g].start = is_on && note_ok && on_sel[g];
			assign cmd[g].stop  = is_off && note_ok && off_sel[g];

			vae_voice u_voice (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (adv),
				.cmd       (cmd[g]),
				.cfg       (cfg),
				.sus_level (sus_level),
				.note_in   (note_s1),
				.stage     (stage[g]),
				.note      (vnote[g]),
				.level_nxt (lvl_nxt[g])
			);
		end
		for (g = 0; g < 4; g++) begin : g_level
			if (g < NV) begin : g_real
				assign level_d[g] = lvl_nxt[g];
			end else begin : g_none
				assign level_d[g] = 7'd0;
			end
		end
	endgenerate

	always_comb begin
		hit_d  = vae_pkg::NO_VOICE;
		step_d = 24'd0;
		rej_d  = (is_on || is_off) && !note_ok;
		if (is_on && note_ok) begin
			step_d = vae_pkg::note_step(note_s1);
		end
		for (int v = 0; v < vae_pkg::HIT_VOICES; v++) begin
			if ((is_on && note_ok && on_sel[v]) || (is_off && note_ok && off_sel[v])) begin
				hit_d = 3'(v);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q <= level_d;
			hit_q   <= hit_d;
			step_q  <= step_d;
			rej_q   <= rej_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign level_voice0  = level_q[0];
	assign level_voice1  = level_q[1];
	assign level_voice2  = level_q[2];
	assign level_voice3  = level_q[3];
	assign voice_hit     = hit_q;
	assign phase_step    = step_q;
	assign note_rejected = rej_q;

endmodule

@@ rtl/core/vae_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vae_cfg
// Configuration register file: envelope steps, sustain position, mode.
// ----------------------------------------------------------------------------
module vae_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output vae_pkg::cfg_t cfg
);

	vae_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_step   <= 32'd1048576;
			cfg_q.decay_step    <= 32'd1048576;
			cfg_q.release_step  <= 32'd1048576;
			cfg_q.sustain_index <= 12'd2048;
			cfg_q.use_envelope  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vae_pkg::CFG_ATTACK_STEP:  cfg_q.attack_step   <= cfg_data;
				vae_pkg::CFG_DECAY_STEP:   cfg_q.decay_step    <= cfg_data;
				vae_pkg::CFG_RELEASE_STEP: cfg_q.release_step  <= cfg_data;
				vae_pkg::CFG_SUSTAIN_IDX:  cfg_q.sustain_index <= cfg_data[11:0];
				vae_pkg::CFG_USE_ENVELOPE: cfg_q.use_envelope  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/vae_voice.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vae_voice
// One voice: envelope stage, index, level and held note, updated per item.
// ----------------------------------------------------------------------------
module vae_voice (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  vae_pkg::voice_cmd_t cmd,
	input  vae_pkg::cfg_t       cfg,
	input  logic [6:0]          sus_level,
	input  logic [6:0]          note_in,
	output vae_pkg::stage_t     stage,
	output logic [6:0]          note,
	output logic [6:0]          level_nxt
);

	vae_pkg::stage_t stage_q, stage_d;
	logic [31:0]     idx_q, idx_d, idx_n;
	logic [6:0]      lvl_q, lvl_d, lv;
	logic [6:0]      note_q, note_d;

	assign stage     = stage_q;
	assign note      = note_q;
	assign level_nxt = lvl_d;

	always_comb begin
		stage_d = stage_q;
		idx_d   = idx_q;
		lvl_d   = lvl_q;
		note_d  = note_q;
		idx_n   = idx_q;
		lv      = lvl_q;
		if (cmd.tick) begin
			unique case (stage_q)
				vae_pkg::ST_ATTACK: begin
					idx_n = idx_q + cfg.attack_step;
					lv    = vae_pkg::level_of(idx_n);
					if (lv > vae_pkg::LVL_PEAK_TRIG) begin
						lv      = vae_pkg::LVL_MAX;
						stage_d = vae_pkg::ST_DECAY;
					end
					idx_d = idx_n;
					lvl_d = lv;
				end
				vae_pkg::ST_DECAY: begin
					idx_n = idx_q - cfg.decay_step;
					lv    = vae_pkg::level_of(idx_n);
					if (lv < sus_level) begin
						lv      = sus_level;
						stage_d = vae_pkg::ST_SUSTAIN;
					end
					idx_d = idx_n;
					lvl_d = lv;
				end
				vae_pkg::ST_SUSTAIN: lvl_d = sus_level;
				vae_pkg::ST_RELEASE: begin
					idx_n = idx_q - cfg.release_step;
					lv    = vae_pkg::level_of(idx_n);
					idx_d = idx_n;
					if (lv < vae_pkg::LVL_FLOOR) begin
						lv      = 7'd0;
						idx_d   = 32'd0;
						stage_d = vae_pkg::ST_IDLE;
					end
					lvl_d = lv;
				end
				default: ;
			endcase
		end else if (cmd.start) begin
			note_d = note_in;
			if (cfg.use_envelope) begin
				stage_d = vae_pkg::ST_ATTACK;
				idx_d   = 32'd0;
			end else begin
				stage_d = vae_pkg::ST_SUSTAIN;
			end
		end else if (cmd.stop) begin
			if (cfg.use_envelope) begin
				stage_d = vae_pkg::ST_RELEASE;
			end else begin
				stage_d = vae_pkg::ST_IDLE;
				lvl_d   = 7'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= vae_pkg::ST_IDLE;
			idx_q   <= 32'd0;
			lvl_q   <= 7'd0;
			note_q  <= 7'd0;
		end else if (en) begin
			stage_q <= stage_d;
			idx_q   <= idx_d;
			lvl_q   <= lvl_d;
			note_q  <= note_d;
		end
	end

endmodule

@@ rtl/core/vae_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vae_checker
// Port-level checks of the voice allocator envelope core.
// ----------------------------------------------------------------------------
module vae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  level_voice0,
	input logic [2:0]  voice_hit,
	input logic [23:0] phase_step,
	input logic        note_rejected
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_voice0) &&
		$stable(voice_hit) && $stable(phase_step))
		else $error("result changed while stalled");

	// input side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> voice_hit <= vae_pkg::NO_VOICE)
		else $error("voice number out of range");

	// a rejected note touches no voice and reports no step
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && note_rejected |-> voice_hit == vae_pkg::NO_VOICE && phase_step == 24'd0)
		else $error("rejected note reported a voice or step");

endmodule

bind voice_allocator_adsr_envelope_core vae_checker u_vae_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.level_voice0  (level_voice0),
	.voice_hit     (voice_hit),
	.phase_step    (phase_step),
	.note_rejected (note_rejected)
);
